FILE: sv/wbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, widths, register codes and constants for the windowed boiler thermostat.
// Has no dependencies. The interfaces, the evaluation logic, the top level and the checker use it.

package wbt_pkg;

	localparam int unsigned MINUTE_W = 11;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned TEMP_W   = 12;
	localparam int unsigned SP_W     = 11;
	localparam int unsigned HYST_W   = 8;
	localparam int unsigned SRC_W    = 2;
	localparam int unsigned WIN_W    = 2;
	localparam int unsigned PADDR_W  = 5;
	localparam int unsigned PDATA_W  = 32;

	// Minimum time the relay stays on after the last demand, in milliseconds.
	localparam logic [TIME_W-1:0] MIN_HOLD_MS = 32'd10000;

	localparam logic [SP_W-1:0]   SETPOINT_RST = 11'd800;
	localparam logic [HYST_W-1:0] HYST_RST     = 8'd32;

	typedef enum logic [2:0] {
		REG_NIGHT_START    = 3'd0,
		REG_NIGHT_END      = 3'd1,
		REG_DAY_START      = 3'd2,
		REG_DAY_END        = 3'd3,
		REG_DAY_SETPOINT   = 3'd4,
		REG_NIGHT_SETPOINT = 3'd5,
		REG_BOILER_SOURCES = 3'd6,
		REG_HYSTERESIS     = 3'd7
	} reg_idx_t;

	typedef enum logic [WIN_W-1:0] {
		WIN_NONE  = 2'd0,
		WIN_NIGHT = 2'd1,
		WIN_DAY   = 2'd2
	} win_t;

	typedef struct packed {
		logic [MINUTE_W-1:0] night_start;
		logic [MINUTE_W-1:0] night_end;
		logic [MINUTE_W-1:0] day_start;
		logic [MINUTE_W-1:0] day_end;
		logic [SP_W-1:0]     day_setpoint;
		logic [SP_W-1:0]     night_setpoint;
		logic [SRC_W-1:0]    boiler_sources;
		logic [HYST_W-1:0]   hysteresis;
	} cfg_t;

	typedef struct packed {
		logic              relay;
		logic [TIME_W-1:0] last_demand_ms;
	} state_t;

	typedef struct packed {
		logic            relay_on;
		win_t            active_window;
		logic [SP_W-1:0] active_setpoint;
		logic            heat_demand;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/wbt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for tick requests and thermostat results.
// Depends on wbt_pkg for the field widths.

interface wbt_tick_if;
	logic                              valid;
	logic                              ready;
	logic [wbt_pkg::MINUTE_W-1:0]      minute_of_day;
	logic [wbt_pkg::TIME_W-1:0]        now_ms;
	logic signed [wbt_pkg::TEMP_W-1:0] tank_temp;

	modport source (output valid, minute_of_day, now_ms, tank_temp, input ready);
	modport sink   (input valid, minute_of_day, now_ms, tank_temp, output ready);
endinterface

interface wbt_result_if;
	logic                      valid;
	logic                      ready;
	logic                      relay_on;
	logic [wbt_pkg::WIN_W-1:0] active_window;
	logic [wbt_pkg::SP_W-1:0]  active_setpoint;
	logic                      heat_demand;

	modport source (output valid, relay_on, active_window, active_setpoint, heat_demand,
		input ready);
	modport sink   (input valid, relay_on, active_window, active_setpoint, heat_demand,
		output ready);
endinterface

`default_nettype wire

FILE: sv/windowed_boiler_thermostat.sv
`timescale 1ns / 1ps
`default_nettype none
// Windowed boiler thermostat: one result per tick request, at most one request per cycle.
// A request is first captured in the tick register, and its result is then loaded into the
// result register that drives the output.
// Throughput: one request per cycle while results are taken; the relay state is updated in the
// same edge that loads the result register, so the next tick sees it at once.
// Reset (arst_n low, asynchronous) clears both registers' valid flags, turns the relay off,
// clears the last demand time and restores every configuration register to its reset value.

module windowed_boiler_thermostat #(
	parameter logic [wbt_pkg::TIME_W-1:0] MIN_HOLD_MS = wbt_pkg::MIN_HOLD_MS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	wbt_tick_if.sink                           tick,
	wbt_result_if.source                       result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wbt_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [wbt_pkg::PDATA_W-1:0]   pwdata,
	output logic      [wbt_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);

	// ------------------------------------------------------------------
	// Configuration registers. The port never stalls, so a write lands at
	// the edge that completes its access phase. Registers sit at byte
	// address four times their index; the low two address bits are ignored.
	// ------------------------------------------------------------------
	wbt_pkg::cfg_t     cfg_q;
	wbt_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = wbt_pkg::reg_idx_t'(paddr[wbt_pkg::PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.night_start    <= '0;
			cfg_q.night_end      <= '0;
			cfg_q.day_start      <= '0;
			cfg_q.day_end        <= '0;
			cfg_q.day_setpoint   <= wbt_pkg::SETPOINT_RST;
			cfg_q.night_setpoint <= wbt_pkg::SETPOINT_RST;
			cfg_q.boiler_sources <= '0;
			cfg_q.hysteresis     <= wbt_pkg::HYST_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				wbt_pkg::REG_NIGHT_START:    cfg_q.night_start    <= pwdata[wbt_pkg::MINUTE_W-1:0];
				wbt_pkg::REG_NIGHT_END:      cfg_q.night_end      <= pwdata[wbt_pkg::MINUTE_W-1:0];
				wbt_pkg::REG_DAY_START:      cfg_q.day_start      <= pwdata[wbt_pkg::MINUTE_W-1:0];
				wbt_pkg::REG_DAY_END:        cfg_q.day_end        <= pwdata[wbt_pkg::MINUTE_W-1:0];
				wbt_pkg::REG_DAY_SETPOINT:   cfg_q.day_setpoint   <= pwdata[wbt_pkg::SP_W-1:0];
				wbt_pkg::REG_NIGHT_SETPOINT: cfg_q.night_setpoint <= pwdata[wbt_pkg::SP_W-1:0];
				wbt_pkg::REG_BOILER_SOURCES: cfg_q.boiler_sources <= pwdata[wbt_pkg::SRC_W-1:0];
				wbt_pkg::REG_HYSTERESIS:     cfg_q.hysteresis     <= pwdata[wbt_pkg::HYST_W-1:0];
				default: ;
			endcase
		end
	end

	// Reads are zero-extended to the data width.
	always_comb begin
		unique case (reg_idx)
			wbt_pkg::REG_NIGHT_START:    prdata = wbt_pkg::PDATA_W'(cfg_q.night_start);
			wbt_pkg::REG_NIGHT_END:      prdata = wbt_pkg::PDATA_W'(cfg_q.night_end);
			wbt_pkg::REG_DAY_START:      prdata = wbt_pkg::PDATA_W'(cfg_q.day_start);
			wbt_pkg::REG_DAY_END:        prdata = wbt_pkg::PDATA_W'(cfg_q.day_end);
			wbt_pkg::REG_DAY_SETPOINT:   prdata = wbt_pkg::PDATA_W'(cfg_q.day_setpoint);
			wbt_pkg::REG_NIGHT_SETPOINT: prdata = wbt_pkg::PDATA_W'(cfg_q.night_setpoint);
			wbt_pkg::REG_BOILER_SOURCES: prdata = wbt_pkg::PDATA_W'(cfg_q.boiler_sources);
			wbt_pkg::REG_HYSTERESIS:     prdata = wbt_pkg::PDATA_W'(cfg_q.hysteresis);
			default:                     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Tick register. It moves on whenever the result register is empty or
	// being emptied, and it accepts a new request in that same cycle, so
	// ticks flow one per cycle and stall only when results back up.
	// ------------------------------------------------------------------
	logic                              valid_s1;
	logic [wbt_pkg::MINUTE_W-1:0]      minute_s1;
	logic [wbt_pkg::TIME_W-1:0]        now_s1;
	logic signed [wbt_pkg::TEMP_W-1:0] temp_s1;
	logic                              out_valid_q;
	logic                              advance;
	logic                              tick_take;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;
	assign tick_take  = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			minute_s1 <= tick.minute_of_day;
			now_s1    <= tick.now_ms;
			temp_s1   <= tick.tank_temp;
		end
	end

	// ------------------------------------------------------------------
	// Evaluation and controller state. The relay and the last demand time
	// change only when a tick leaves the tick register, so each tick sees
	// exactly what its predecessor left behind.
	// ------------------------------------------------------------------
	wbt_pkg::state_t  state_q;
	wbt_pkg::state_t  state_nxt;
	wbt_pkg::result_t res_nxt;
	wbt_pkg::result_t res_q;

	wbt_eval #(
		.MIN_HOLD_MS (MIN_HOLD_MS)
	) u_eval (
		.minute_of_day (minute_s1),
		.now_ms        (now_s1),
		.tank_temp     (temp_s1),
		.cfg           (cfg_q),
		.state_cur     (state_q),
		.state_nxt     (state_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.relay          <= 1'b0;
			state_q.last_demand_ms <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Result register. It holds a finished result while the consumer
	// stalls; the tick register behind it keeps the next request.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.relay_on        = res_q.relay_on;
	assign result.active_window   = res_q.active_window;
	assign result.active_setpoint = res_q.active_setpoint;
	assign result.heat_demand     = res_q.heat_demand;

endmodule

`default_nettype wire

FILE: sv/wbt_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// Combinational evaluation of one tick: window test, setpoint choice, hysteresis and hold.
// Depends on wbt_pkg.

module wbt_eval #(
	parameter logic [wbt_pkg::TIME_W-1:0] MIN_HOLD_MS = wbt_pkg::MIN_HOLD_MS
) (
	input  wire logic [wbt_pkg::MINUTE_W-1:0]      minute_of_day,
	input  wire logic [wbt_pkg::TIME_W-1:0]        now_ms,
	input  wire logic signed [wbt_pkg::TEMP_W-1:0] tank_temp,
	input  wire wbt_pkg::cfg_t                     cfg,
	input  wire wbt_pkg::state_t                   state_cur,
	output wbt_pkg::state_t                        state_nxt,
	output wbt_pkg::result_t                       res
);

	localparam int unsigned CMP_W = wbt_pkg::TEMP_W + 2;

	// A window with start after end wraps past midnight; equal bounds give an empty window.
	function automatic logic in_window(
		input logic [wbt_pkg::MINUTE_W-1:0] t,
		input logic [wbt_pkg::MINUTE_W-1:0] lo,
		input logic [wbt_pkg::MINUTE_W-1:0] hi
	);
		if (lo <= hi) begin
			return (t >= lo) && (t < hi);
		end
		return (t >= lo) || (t < hi);
	endfunction

	logic                     night;
	logic                     day;
	logic                     boiler;
	logic                     hold_done;
	logic                     demand;
	logic [wbt_pkg::SP_W-1:0] sp;
	logic signed [CMP_W-1:0]  temp_x;
	logic signed [CMP_W-1:0]  sp_x;
	logic signed [CMP_W-1:0]  hyst_x;
	logic signed [CMP_W-1:0]  band_lo;
	logic signed [CMP_W-1:0]  band_hi;
	logic [wbt_pkg::TIME_W-1:0] since_demand;
	wbt_pkg::win_t            win;

	always_comb begin
		night = in_window(minute_of_day, cfg.night_start, cfg.night_end);
		day   = in_window(minute_of_day, cfg.day_start, cfg.day_end);

		priority if (day) begin
			win    = wbt_pkg::WIN_DAY;
			sp     = cfg.day_setpoint;
			boiler = cfg.boiler_sources[0];
		end else if (night) begin
			win    = wbt_pkg::WIN_NIGHT;
			sp     = cfg.night_setpoint;
			boiler = cfg.boiler_sources[1];
		end else begin
			win    = wbt_pkg::WIN_NONE;
			sp     = '0;
			boiler = 1'b0;
		end

		// The band edges are formed wide enough that neither can overflow.
		temp_x  = CMP_W'(tank_temp);
		sp_x    = $signed({{(CMP_W - wbt_pkg::SP_W){1'b0}}, sp});
		hyst_x  = $signed({{(CMP_W - wbt_pkg::HYST_W){1'b0}}, cfg.hysteresis});
		band_lo = sp_x - hyst_x;
		band_hi = sp_x + hyst_x;

		demand = boiler && (temp_x < band_lo);

		// Elapsed time is taken modulo 2^32, so a wrap of the millisecond counter is harmless.
		since_demand = now_ms - state_cur.last_demand_ms;
		hold_done    = since_demand >= MIN_HOLD_MS;

		state_nxt = state_cur;
		priority if (demand) begin
			state_nxt.relay          = 1'b1;
			state_nxt.last_demand_ms = now_ms;
		end else if (!boiler || (temp_x > band_hi)) begin
			if (hold_done) begin
				state_nxt.relay = 1'b0;
			end
		end else begin
			state_nxt = state_cur;
		end

		res.relay_on        = state_nxt.relay;
		res.active_window   = win;
		res.active_setpoint = sp;
		res.heat_demand     = demand;
	end

endmodule

`default_nettype wire

FILE: sv/wbt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the windowed boiler thermostat, bound to the top level.
// Depends on wbt_pkg and on the top level's result channel.

module wbt_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic                      relay_on,
	input wire logic [wbt_pkg::WIN_W-1:0] active_window,
	input wire logic [wbt_pkg::SP_W-1:0]  active_setpoint,
	input wire logic                      heat_demand
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its fields.
	a_hold_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(relay_on) && $stable(active_window)
			&& $stable(active_setpoint) && $stable(heat_demand))
		else $error("result fields changed while stalled");

	// Demand always switches the relay on in the same result.
	a_demand_relay: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && heat_demand |-> relay_on)
		else $error("heat demand without relay on");

	// With no window active there is neither a setpoint nor a demand.
	a_no_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (active_window == wbt_pkg::WIN_NONE)
			|-> (active_setpoint == '0) && !heat_demand)
		else $error("setpoint or demand reported with no active window");

endmodule

bind windowed_boiler_thermostat wbt_checker u_wbt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.relay_on        (result.relay_on),
	.active_window   (result.active_window),
	.active_setpoint (result.active_setpoint),
	.heat_demand     (result.heat_demand)
);

`default_nettype wire

FILE: bench/windowed_boiler_thermostat_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the windowed boiler thermostat: directed table, then random ticks.
// Depends on wbt_pkg, the tick and result channel interfaces and the thermostat top level.

module windowed_boiler_thermostat_tb;

	localparam int LIMIT_CYCLES    = 400000;
	localparam int TICKS_PER_PHASE = 205;
	localparam int PHASES          = 8;
	// Phase in which the result side holds off long enough for the block to back up.
	localparam int BACKLOG_PHASE   = 4;
	localparam int BACKLOG_CYCLES  = 300;

	// One row of the directed table: either a register write or a tick request. Rows whose
	// outcome is obvious carry it typed in; the rest are checked against the thermostat model.
	typedef struct {
		bit                 is_cfg;
		wbt_pkg::reg_idx_t  idx;
		logic [31:0]        value;
		logic [10:0]        minute;
		logic [31:0]        now;
		logic signed [11:0] temp;
		bit                 typed;
		wbt_pkg::result_t   want;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [wbt_pkg::PADDR_W-1:0]   paddr = '0;
	logic [wbt_pkg::PDATA_W-1:0]   pwdata = '0;
	logic [wbt_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;

	wbt_tick_if   tick_ch ();
	wbt_result_if result_ch ();

	windowed_boiler_thermostat dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Our own copy of the thermostat: settings, relay state and the last demand time.
	wbt_pkg::cfg_t model_cfg;
	logic          model_relay;
	logic [31:0]   model_last_demand;

	wbt_pkg::result_t relay_outcomes[$];
	stim_row_t        stim_table[$];

	int mismatches = 0;
	int cycle_count = 0;
	int ticks_sent = 0;
	int cfg_writes = 0;
	int results_seen = 0;
	int demand_seen = 0;
	int relay_on_seen = 0;
	int day_seen = 0;
	int night_seen = 0;
	int none_seen = 0;

	// Percentages of cycles in which the sender idles and the receiver stalls, and the
	// length of a deliberate hold-off on the result side.
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	int sink_hold_left = 0;

	always #5 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.minute_of_day = '0;
		tick_ch.now_ms = '0;
		tick_ch.tank_temp = '0;
		result_ch.ready = 1'b0;
	end

	// A minute lies in a window when it is at or past the start and before the end; a window
	// whose start lies after its end runs on past midnight. Equal bounds give an empty window.
	function automatic bit in_span(input logic [10:0] t, input logic [10:0] lo,
		input logic [10:0] hi);
		if (lo <= hi) begin
			return (t >= lo) && (t < hi);
		end else begin
			return (t >= lo) || (t < hi);
		end
	endfunction

	// Works out the result of one tick and moves the relay state and demand time on.
	function automatic wbt_pkg::result_t thermostat_eval(input logic [10:0] minute,
		input logic [31:0] now, input logic signed [11:0] temp);
		wbt_pkg::result_t r;
		logic             night, day, boiler, hold_done;
		logic [31:0]      elapsed;
		int               t_int, sp_int, hy_int, band_lo, band_hi;
		r.relay_on = 1'b0;
		r.active_window = wbt_pkg::WIN_NONE;
		r.active_setpoint = '0;
		r.heat_demand = 1'b0;
		night = in_span(minute, model_cfg.night_start, model_cfg.night_end);
		day = in_span(minute, model_cfg.day_start, model_cfg.day_end);
		// The hold time is measured across the wrap of the millisecond counter.
		elapsed = now - model_last_demand;
		hold_done = (elapsed >= wbt_pkg::MIN_HOLD_MS);
		t_int = temp;
		boiler = 1'b0;
		if (day) begin
			r.active_window = wbt_pkg::WIN_DAY;
			r.active_setpoint = model_cfg.day_setpoint;
			boiler = model_cfg.boiler_sources[0];
		end else if (night) begin
			r.active_window = wbt_pkg::WIN_NIGHT;
			r.active_setpoint = model_cfg.night_setpoint;
			boiler = model_cfg.boiler_sources[1];
		end
		if (!day && !night) begin
			if (hold_done) model_relay = 1'b0;
		end else begin
			// The band is worked out at integer width, so no edge of it can overflow.
			sp_int = r.active_setpoint;
			hy_int = model_cfg.hysteresis;
			band_lo = sp_int - hy_int;
			band_hi = sp_int + hy_int;
			r.heat_demand = boiler && (t_int < band_lo);
			if (!boiler) begin
				if (hold_done) model_relay = 1'b0;
			end else if (r.heat_demand) begin
				model_relay = 1'b1;
				model_last_demand = now;
			end else if (t_int > band_hi && hold_done) begin
				model_relay = 1'b0;
			end
		end
		r.relay_on = model_relay;
		return r;
	endfunction

	// Records a register value in the model and returns it as the register should read back.
	function automatic logic [31:0] store_setting(input wbt_pkg::reg_idx_t idx,
		input logic [31:0] value);
		case (idx)
			wbt_pkg::REG_NIGHT_START: model_cfg.night_start = value[10:0];
			wbt_pkg::REG_NIGHT_END: model_cfg.night_end = value[10:0];
			wbt_pkg::REG_DAY_START: model_cfg.day_start = value[10:0];
			wbt_pkg::REG_DAY_END: model_cfg.day_end = value[10:0];
			wbt_pkg::REG_DAY_SETPOINT: model_cfg.day_setpoint = value[10:0];
			wbt_pkg::REG_NIGHT_SETPOINT: model_cfg.night_setpoint = value[10:0];
			wbt_pkg::REG_BOILER_SOURCES: model_cfg.boiler_sources = value[1:0];
			wbt_pkg::REG_HYSTERESIS: model_cfg.hysteresis = value[7:0];
			default: ;
		endcase
		case (idx)
			wbt_pkg::REG_BOILER_SOURCES: return {30'd0, value[1:0]};
			wbt_pkg::REG_HYSTERESIS: return {24'd0, value[7:0]};
			default: return {21'd0, value[10:0]};
		endcase
	endfunction

	function automatic logic [10:0] rand_minute();
		if ($urandom_range(99) < 92) return 11'($urandom_range(0, 1439));
		return 11'($urandom_range(1440, 2047));
	endfunction

	function automatic logic [10:0] rand_setpoint();
		case ($urandom_range(9))
			0: return 11'd0;
			1: return 11'd1600;
			2: return 11'd2047;
			default: return 11'($urandom_range(0, 1600));
		endcase
	endfunction

	function automatic void row_cfg(input wbt_pkg::reg_idx_t idx, input logic [31:0] value);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.value = value;
		stim_table.push_back(r);
	endfunction

	function automatic void row_tick(input logic [10:0] minute, input logic [31:0] now,
		input logic signed [11:0] temp, input bit typed, input logic relay,
		input wbt_pkg::win_t win, input logic [10:0] sp, input logic demand);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.minute = minute;
		r.now = now;
		r.temp = temp;
		r.typed = typed;
		r.want.relay_on = relay;
		r.want.active_window = win;
		r.want.active_setpoint = sp;
		r.want.heat_demand = demand;
		stim_table.push_back(r);
	endfunction

	// Register write followed by a read-back. The block is idle whenever this is called,
	// so the model settings can change at once. The bus is left idle at the end.
	task automatic cfg_write(input wbt_pkg::reg_idx_t idx, input logic [31:0] value);
		logic [31:0] stored;
		stored = store_setting(idx, value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// Straight on into the read; select stays high.
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== stored) begin
			mismatches++;
			$display("%0t: register %s read back expected %0d, got %0d", $time, idx.name(),
				stored, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		cfg_writes++;
	endtask

	// Offers one tick request, with random idle cycles first, and records its outcome once
	// it is taken. Valid is left high so that back-to-back requests need no gap.
	task automatic offer_tick(input logic [10:0] minute, input logic [31:0] now,
		input logic signed [11:0] temp, input bit typed, input wbt_pkg::result_t want);
		wbt_pkg::result_t predicted;
		while ($urandom_range(99) < src_gap_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.minute_of_day <= minute;
		tick_ch.now_ms <= now;
		tick_ch.tank_temp <= temp;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		predicted = thermostat_eval(minute, now, temp);
		relay_outcomes.push_back(typed ? want : predicted);
		ticks_sent++;
	endtask

	// Stops offering and waits until every outcome has come back, then lets the pipeline settle.
	task automatic drain_results();
		tick_ch.valid <= 1'b0;
		wait (relay_outcomes.size() == 0);
		@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_result();
		wbt_pkg::result_t want;
		logic [31:0]      want_f[4];
		logic [31:0]      got_f[4];
		string            names[4];
		if (relay_outcomes.size() == 0) begin
			mismatches++;
			$display("%0t: result with nothing outstanding, got relay %0d window %0d sp %0d demand %0d",
				$time, result_ch.relay_on, result_ch.active_window, result_ch.active_setpoint,
				result_ch.heat_demand);
		end else begin
			want = relay_outcomes.pop_front();
			names[0] = "relay_on";
			names[1] = "active_window";
			names[2] = "active_setpoint";
			names[3] = "heat_demand";
			want_f[0] = 32'(want.relay_on);
			want_f[1] = 32'(want.active_window);
			want_f[2] = 32'(want.active_setpoint);
			want_f[3] = 32'(want.heat_demand);
			got_f[0] = 32'(result_ch.relay_on);
			got_f[1] = 32'(result_ch.active_window);
			got_f[2] = 32'(result_ch.active_setpoint);
			got_f[3] = 32'(result_ch.heat_demand);
			for (int i = 0; i < 4; i++) begin
				if (got_f[i] !== want_f[i]) begin
					mismatches++;
					$display("%0t: %s expected %0d, got %0d", $time, names[i], want_f[i],
						got_f[i]);
				end
			end
			results_seen++;
			if (want.heat_demand) demand_seen++;
			if (want.relay_on) relay_on_seen++;
			case (want.active_window)
				wbt_pkg::WIN_DAY: day_seen++;
				wbt_pkg::WIN_NIGHT: night_seen++;
				default: none_seen++;
			endcase
		end
	endtask

	// Result side: takes each result on the edge where valid and ready are both high, then
	// chooses ready for the next cycle. A pending hold-off keeps ready low throughout.
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) check_result();
		if (sink_hold_left > 0) begin
			sink_hold_left = sink_hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("%0t: no progress within %0d cycles", $time, LIMIT_CYCLES);
		$display("simulation failed");
		$finish;
	end

	initial begin
		int                 gap_by_mode[4];
		int                 stall_by_mode[4];
		int                 roll, centre, hy, temp_i;
		logic [10:0]        ns, ds, minute;
		logic [31:0]        clock_ms;
		logic signed [11:0] temp;

		gap_by_mode = '{0, 61, 0, 19};
		stall_by_mode = '{0, 0, 61, 19};

		model_cfg.night_start = '0;
		model_cfg.night_end = '0;
		model_cfg.day_start = '0;
		model_cfg.day_end = '0;
		model_cfg.day_setpoint = wbt_pkg::SETPOINT_RST;
		model_cfg.night_setpoint = wbt_pkg::SETPOINT_RST;
		model_cfg.boiler_sources = '0;
		model_cfg.hysteresis = wbt_pkg::HYST_RST;
		model_relay = 1'b0;
		model_last_demand = '0;

		// Directed table. With the reset settings both windows are empty, so the block can only
		// report no window, no setpoint, no demand and the relay off, whatever the tick says.
		row_tick(11'd0, 32'd0, -12'sd2048, 1'b1, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		row_tick(11'd2047, 32'hFFFF_FFFF, 12'sd2047, 1'b1, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		row_tick(11'd1439, 32'h5555_5555, 12'sd0, 1'b1, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// Night from 22:00 running past midnight to 06:00, day 05:00 to 20:00, both on the
		// boiler, widest band, night setpoint at the bottom and day setpoint at the top.
		row_cfg(wbt_pkg::REG_NIGHT_START, 32'd1320);
		row_cfg(wbt_pkg::REG_NIGHT_END, 32'd360);
		row_cfg(wbt_pkg::REG_DAY_START, 32'd300);
		row_cfg(wbt_pkg::REG_DAY_END, 32'd1200);
		row_cfg(wbt_pkg::REG_DAY_SETPOINT, 32'd1600);
		row_cfg(wbt_pkg::REG_NIGHT_SETPOINT, 32'd0);
		row_cfg(wbt_pkg::REG_BOILER_SOURCES, 32'd3);
		row_cfg(wbt_pkg::REG_HYSTERESIS, 32'd255);
		// Coldest tank at night: demand, relay on.
		row_tick(11'd1400, 32'd100, -12'sd2048, 1'b1, 1'b1, wbt_pkg::WIN_NIGHT, 11'd0, 1'b1);
		// Both windows hold, so day wins; hot tank but the hold time has not run out.
		row_tick(11'd330, 32'd200, 12'sd2047, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// Exactly the hold time after the demand: the relay may now drop.
		row_tick(11'd700, 32'd10100, 12'sd2047, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// Between the windows: nothing active.
		row_tick(11'd1300, 32'd20000, -12'sd2048, 1'b1, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// Night end is exclusive, day is active; demand stamped just before the counter wraps.
		row_tick(11'd360, 32'hFFFF_FFF0, -12'sd2048, 1'b1, 1'b1, wbt_pkg::WIN_DAY, 11'd1600,
			1'b1);
		// Day end is exclusive. One millisecond short of the hold time across the wrap,
		// then exactly on it.
		row_tick(11'd1200, 32'h0000_26FF, 12'sd0, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		row_tick(11'd1319, 32'h0000_2700, 12'sd0, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// Night start is inclusive; the temperature sits inside the band, relay unchanged.
		row_tick(11'd1320, 32'h0001_0000, 12'sd100, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// No band at all, a day setpoint past its usual range, and only day on the boiler.
		row_cfg(wbt_pkg::REG_HYSTERESIS, 32'd0);
		row_cfg(wbt_pkg::REG_DAY_SETPOINT, 32'd2047);
		row_cfg(wbt_pkg::REG_NIGHT_SETPOINT, 32'd1600);
		row_cfg(wbt_pkg::REG_BOILER_SOURCES, 32'd1);
		row_tick(11'd1000, 32'h8000_0000, 12'sd2046, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// Temperature equal to the setpoint is neither below nor above: relay held.
		row_tick(11'd1000, 32'h8000_0001, 12'sd2047, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// Night window without the boiler: relay drops once the hold time is over.
		row_tick(11'd30, 32'h8000_2710, -12'sd2048, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		// Night from the last minute wrapping to an end of zero, and an empty day window at
		// the top of the field.
		row_cfg(wbt_pkg::REG_NIGHT_START, 32'd1439);
		row_cfg(wbt_pkg::REG_NIGHT_END, 32'd0);
		row_cfg(wbt_pkg::REG_DAY_START, 32'd2047);
		row_cfg(wbt_pkg::REG_DAY_END, 32'd2047);
		row_tick(11'd1439, 32'h8001_0000, -12'sd1, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		row_tick(11'd2047, 32'h8001_0001, 12'sd1, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0, 1'b0);
		row_tick(11'd1438, 32'h8002_0000, -12'sd2048, 1'b0, 1'b0, wbt_pkg::WIN_NONE, 11'd0,
			1'b0);

		// Reset once, then release it on a clock edge.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg) begin
				drain_results();
				cfg_write(stim_table[i].idx, stim_table[i].value);
			end else begin
				offer_tick(stim_table[i].minute, stim_table[i].now, stim_table[i].temp,
					stim_table[i].typed, stim_table[i].want);
			end
		end

		// Random phases. Each starts from an idle block with a fresh set of registers and
		// cycles through the handshake regimes: free flow, idle sender, stalling receiver
		// and both together.
		clock_ms = 32'd50000;
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			src_gap_pct = gap_by_mode[phase % 4];
			sink_stall_pct = stall_by_mode[phase % 4];
			ns = rand_minute();
			ds = rand_minute();
			cfg_write(wbt_pkg::REG_NIGHT_START, 32'(ns));
			cfg_write(wbt_pkg::REG_NIGHT_END, 32'(($urandom_range(9) == 0) ? ns : rand_minute()));
			cfg_write(wbt_pkg::REG_DAY_START, 32'(ds));
			cfg_write(wbt_pkg::REG_DAY_END, 32'(($urandom_range(9) == 0) ? ds : rand_minute()));
			cfg_write(wbt_pkg::REG_DAY_SETPOINT, 32'(rand_setpoint()));
			cfg_write(wbt_pkg::REG_NIGHT_SETPOINT, 32'(rand_setpoint()));
			cfg_write(wbt_pkg::REG_BOILER_SOURCES, 32'($urandom_range(0, 3)));
			case ($urandom_range(5))
				0: cfg_write(wbt_pkg::REG_HYSTERESIS, 32'd0);
				1: cfg_write(wbt_pkg::REG_HYSTERESIS, 32'd255);
				default: cfg_write(wbt_pkg::REG_HYSTERESIS, 32'($urandom_range(0, 255)));
			endcase
			// Every third phase runs the millisecond counter through its wrap.
			if (phase % 3 == 2) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 50000));
			// The result side goes quiet for a long stretch while requests keep coming, so the
			// block fills and has to hold its input off.
			if (phase == BACKLOG_PHASE) sink_hold_left = BACKLOG_CYCLES;
			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				// Mostly short steps, so the hold time matters; some steps land near it and a
				// few jump anywhere.
				roll = $urandom_range(99);
				if (roll < 90) begin
					clock_ms = clock_ms + 32'($urandom_range(0, 2500));
				end else if (roll < 97) begin
					clock_ms = clock_ms + 32'($urandom_range(9000, 11000));
				end else begin
					clock_ms = $urandom;
				end
				minute = rand_minute();
				// Most temperatures cluster round one of the setpoints so that the band
				// edges are hit; the rest span the whole sensor range.
				if ($urandom_range(99) < 70) begin
					centre = $urandom_range(1) ? int'(model_cfg.day_setpoint) :
						int'(model_cfg.night_setpoint);
					hy = model_cfg.hysteresis;
					temp_i = centre + int'($urandom_range(0, 2 * hy + 80)) - (hy + 40);
					if (temp_i > 2047) temp_i = 2047;
					if (temp_i < -2048) temp_i = -2048;
				end else begin
					temp_i = int'($urandom_range(0, 4095)) - 2048;
				end
				temp = temp_i[11:0];
				offer_tick(minute, clock_ms, temp, 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("Sent %0d tick requests and %0d register writes over %0d random phases.",
			ticks_sent, cfg_writes, PHASES);
		$display("Checked %0d results: %0d day, %0d night, %0d none, %0d demand, %0d relay on.",
			results_seen, day_seen, night_seen, none_seen, demand_seen, relay_on_seen);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/wbt_pkg.sv
sv/wbt_if.sv
sv/wbt_eval.sv
sv/windowed_boiler_thermostat.sv
sv/wbt_checker.sv
bench/windowed_boiler_thermostat_tb.sv
